FILE: src/alte_pkg.sv
// ----------------------------------------------------------------------------
// alte_pkg
// Shared types and constants for the array list table engine: list capacity,
// derived widths, operation and status codes, request/result beats and the
// word RAM port groups.
// ----------------------------------------------------------------------------
package alte_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [OP_W-1:0]   op;
    logic signed [WORD_W-1:0] value;
    logic        [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic        [POS_W-1:0]  found_position;
    logic signed [WORD_W-1:0] read_data;
    logic        [POS_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

FILE: src/array_list_table_engine.sv
// ----------------------------------------------------------------------------
// array_list_table_engine
// Packed list of signed words with append, read, search, update and delete.
// Append, update, refused and unused ops never go busy. Read waits on the
// registered RAM word; search walks from position 1 to a match or the last
// word; delete at position p moves each later word down one place. Search and
// delete handle one word per cycle. Busy covers read, search and delete, which
// use the single RAM read port. Done is a one-cycle strobe; the receiver cannot
// stall. Synchronous reset empties the list at once; the word RAM is not cleared.
// ----------------------------------------------------------------------------
module array_list_table_engine
  import alte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DELETE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] idx;
  logic [WORD_W-1:0] value_q;

  ram_wr_t           wr;
  ram_rd_t           rd;
  logic [WORD_W-1:0] rdata;

  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic              pos_ok;
  logic [ADDR_W-1:0] pos_addr;
  logic              del_more;
  logic              srch_last;

  alte_word_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Decode position against the current count
  assign pos_ext   = CMP_W'(request.position);
  assign cnt_ext   = CMP_W'(count);
  assign idx_ext   = CMP_W'(idx);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_addr  = ADDR_W'(pos_ext - CMP_W'(1));
  assign del_more  = (idx_ext + CMP_W'(2)) < cnt_ext;
  assign srch_last = (idx_ext + CMP_W'(1)) >= cnt_ext;

  // Drive the RAM ports
  always_comb begin
    wr = '0;
    rd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.op)
            OP_APPEND: begin
              wr.en   = (cnt_ext < CMP_W'(CAPACITY));
              wr.addr = ADDR_W'(count);
              wr.data = request.value;
            end
            OP_READ: begin
              rd.en   = pos_ok;
              rd.addr = pos_addr;
            end
            OP_SEARCH: begin
              rd.en   = (count != '0);
              rd.addr = '0;
            end
            OP_UPDATE: begin
              wr.en   = pos_ok;
              wr.addr = pos_addr;
              wr.data = request.value;
            end
            OP_DELETE: begin
              rd.en   = pos_ok && (pos_ext < cnt_ext);
              rd.addr = ADDR_W'(pos_ext);
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        rd.en   = (rdata != value_q) && !srch_last;
        rd.addr = idx + ADDR_W'(1);
      end
      S_DELETE: begin
        wr.en   = 1'b1;
        wr.addr = idx;
        wr.data = rdata;
        rd.en   = del_more;
        rd.addr = idx + ADDR_W'(2);
      end
      default: begin
      end
    endcase
  end

  // Sequence the ops and register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_q               <= request.value;
            result.status         <= STAT_OK;
            result.found_position <= '0;
            result.read_data      <= '0;
            result.entry_count    <= POS_W'(count);
            case (request.op)
              OP_APPEND: begin
                done <= 1'b1;
                if (cnt_ext < CMP_W'(CAPACITY)) begin
                  count              <= count + CNT_W'(1);
                  result.entry_count <= POS_W'(count + CNT_W'(1));
                end else begin
                  result.status <= STAT_FULL;
                end
              end
              OP_READ: begin
                if (pos_ok) begin
                  state <= S_READ;
                end else begin
                  done          <= 1'b1;
                  result.status <= STAT_BADPOS;
                end
              end
              OP_SEARCH: begin
                idx <= '0;
                if (count != '0) begin
                  state <= S_SEARCH;
                end else begin
                  done          <= 1'b1;
                  result.status <= STAT_NOTFOUND;
                end
              end
              OP_UPDATE: begin
                done <= 1'b1;
                if (!pos_ok) begin
                  result.status <= STAT_BADPOS;
                end
              end
              OP_DELETE: begin
                idx <= pos_addr;
                if (!pos_ok) begin
                  done          <= 1'b1;
                  result.status <= STAT_BADPOS;
                end else if (pos_ext < cnt_ext) begin
                  state <= S_DELETE;
                end else begin
                  // Last word: drop it without moving anything
                  done               <= 1'b1;
                  count              <= count - CNT_W'(1);
                  result.entry_count <= POS_W'(count - CNT_W'(1));
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          done             <= 1'b1;
          result.read_data <= rdata;
          state            <= S_IDLE;
        end
        S_SEARCH: begin
          if (rdata == value_q) begin
            done                  <= 1'b1;
            result.found_position <= POS_W'(idx_ext + CMP_W'(1));
            state                 <= S_IDLE;
          end else if (srch_last) begin
            done          <= 1'b1;
            result.status <= STAT_NOTFOUND;
            state         <= S_IDLE;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_DELETE: begin
          // Move one word down per cycle; advance until the tail is reached
          if (del_more) begin
            idx <= idx + ADDR_W'(1);
          end else begin
            done               <= 1'b1;
            count              <= count - CNT_W'(1);
            result.entry_count <= POS_W'(count - CNT_W'(1));
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/alte_word_ram.sv
// ----------------------------------------------------------------------------
// alte_word_ram
// Word store of the list: one write port and one read port, read data
// registered. No reset: entries are undefined until written.
// ----------------------------------------------------------------------------
module alte_word_ram
  import alte_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [CAPACITY];

  // Write the beat and register the read word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
